@@ src/fwrt_pkg.sv @@
`timescale 1ns / 1ps

package fwrt_pkg;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_ENABLE = 2'd2,
      CMD_TEST   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type       command;
      logic [63:0]   app_key;
      logic [15:0]   port_number;
      logic          allow_flag;
      logic [31:0]   rule_number;
      logic          enable_flag;
   } req_type;

   typedef struct packed {
      status_type    status;
      logic [31:0]   assigned_number;
      logic          verdict_allowed;
   } rsp_type;

   localparam logic [63:0] WILDCARD_KEY = 64'h2A;   // "*"
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0]  CASE_OFFSET  = 8'd32;

   // Fold A-Z to a-z in every byte; other bytes pass unchanged.
   function automatic logic [63:0] fold_name(input logic [63:0] key);
      logic [63:0] r;
      logic [7:0]  ch;
      r = '0;
      for (int b = 0; b < 8; b++) begin
         ch = key[8*b +: 8];
         if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            ch = ch + CASE_OFFSET;
         end
         r[8*b +: 8] = ch;
      end
      return r;
   endfunction

endpackage

@@ src/firewall_rule_table_top.sv @@
`timescale 1ns / 1ps

// Firewall rule table with add, remove, set-enable and test commands.
// Input channel req_*: one item per command, accepted when req_valid is high
// and req_stall is low. The block takes one item at a time; req_stall stays
// high from acceptance until the result is loaded into the output register.
// Result channel rsp_*: exactly one item per command, held in an output
// register until the receiver takes it (rsp_valid high, rsp_stall low).
// One shared slot compare unit walks the table one slot a cycle, behind a
// registered read of the rule memory. A command finishes at the first
// deciding slot (free slot, number match, matching deny rule) or else at the
// last slot, and the next item can be accepted the cycle after the result is
// loaded.
// A stalled receiver holds the result; a finished item waits in the result
// register and the block takes no new item until the output register frees.
// Reset clears all used and enable bits, sets the next rule number to one
// and empties the output register. Rule memory contents need no clearing:
// an entry is only looked at when its used bit is set.
module firewall_rule_table_top #(
   parameter int RULE_SLOTS = 12,
   parameter int NAME_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fwrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fwrt_pkg::rsp_type rsp_data
);

   import fwrt_pkg::*;

   localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
   localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(RULE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(RULE_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   // Keep the low NAME_BYTES bytes, cut at the first zero byte.
   function automatic logic [63:0] shorten_name(input logic [63:0] key);
      logic [63:0] r;
      logic        live;
      r    = '0;
      live = 1'b1;
      for (int b = 0; b < 8; b++) begin
         if (b >= NAME_BYTES || key[8*b +: 8] == 8'h00) begin
            live = 1'b0;
         end
         if (live) begin
            r[8*b +: 8] = key[8*b +: 8];
         end
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   req_type           cur_ff, cur_in;
   logic [63:0]       key_fold_ff, key_fold_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [RULE_SLOTS-1:0] used_ff, used_in;
   logic [RULE_SLOTS-1:0] en_ff, en_in;
   logic [31:0]       next_number_ff, next_number_in;

   // rule memory, one read and one write port
   logic [63:0] mem_app   [RULE_SLOTS];
   logic [15:0] mem_port  [RULE_SLOTS];
   logic [31:0] mem_num   [RULE_SLOTS];
   logic        mem_allow [RULE_SLOTS];
   logic [63:0] rd_app_ff;
   logic [15:0] rd_port_ff;
   logic [31:0] rd_num_ff;
   logic        rd_allow_ff;

   logic        accept;
   logic        issue;
   logic        slot_used;
   logic        slot_en;
   logic        port_ok;
   logic        name_ok;
   logic        hit;
   logic        finish;
   logic        add_write;
   logic        out_free;
   logic [63:0] short_key;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign issue     = (state_ff == S_SCAN) && (idx_ff < SLOT_COUNT);
   assign short_key = shorten_name(req_data.app_key);

   assign slot_used = used_ff[cmp_idx_ff];
   assign slot_en   = en_ff[cmp_idx_ff];
   assign port_ok   = (rd_port_ff == 16'd0) || (rd_port_ff == cur_ff.port_number);
   assign name_ok   = (rd_app_ff == WILDCARD_KEY) || (fold_name(rd_app_ff) == key_fold_ff);

   always_comb begin
      case (cur_ff.command)
         CMD_ADD:    hit = !slot_used;
         CMD_REMOVE: hit = slot_used && (rd_num_ff == cur_ff.rule_number);
         CMD_ENABLE: hit = slot_used && (rd_num_ff == cur_ff.rule_number);
         CMD_TEST:   hit = slot_used && slot_en && port_ok && name_ok && !rd_allow_ff;
         default:    hit = 1'b0;
      endcase
   end

   assign finish    = (state_ff == S_SCAN) && cmp_vld_ff && (hit || cmp_idx_ff == LAST_SLOT);
   assign add_write = finish && hit && (cur_ff.command == CMD_ADD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cmp_vld_in     = issue && !finish;
      cmp_idx_in     = idx_ff[SLOT_W-1:0];
      cur_in         = cur_ff;
      key_fold_in    = key_fold_ff;
      res_in         = res_ff;
      used_in        = used_ff;
      en_in          = en_ff;
      next_number_in = next_number_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_in         = req_data;
               cur_in.app_key = (short_key == 64'd0) ? WILDCARD_KEY : short_key;
               key_fold_in    = fold_name(short_key);
               idx_in         = '0;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (finish) begin
               res_in.status          = ST_OK;
               res_in.assigned_number = 32'd0;
               res_in.verdict_allowed = 1'b0;
               case (cur_ff.command)
                  CMD_ADD: begin
                     if (hit) begin
                        res_in.assigned_number = next_number_ff;
                        used_in[cmp_idx_ff]    = 1'b1;
                        en_in[cmp_idx_ff]      = 1'b1;
                        next_number_in         = next_number_ff + 32'd1;
                     end else begin
                        res_in.status = ST_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit) begin
                        used_in[cmp_idx_ff] = 1'b0;
                        en_in[cmp_idx_ff]   = 1'b0;
                     end else begin
                        res_in.status = ST_NONE;
                     end
                  end
                  CMD_ENABLE: begin
                     if (hit) begin
                        en_in[cmp_idx_ff] = cur_ff.enable_flag;
                     end else begin
                        res_in.status = ST_NONE;
                     end
                  end
                  CMD_TEST: begin
                     res_in.verdict_allowed = !hit;
                  end
                  default: begin
                     res_in.status = ST_NONE;
                  end
               endcase
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_ff         <= '0;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         used_ff        <= '0;
         en_ff          <= '0;
         next_number_ff <= 32'd1;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         cmp_vld_ff     <= cmp_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         used_ff        <= used_in;
         en_ff          <= en_in;
         next_number_ff <= next_number_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      cur_ff      <= cur_in;
      key_fold_ff <= key_fold_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (add_write) begin
         mem_app[cmp_idx_ff]   <= cur_ff.app_key;
         mem_port[cmp_idx_ff]  <= cur_ff.port_number;
         mem_num[cmp_idx_ff]   <= next_number_ff;
         mem_allow[cmp_idx_ff] <= cur_ff.allow_flag;
      end
      if (issue) begin
         rd_app_ff   <= mem_app[idx_ff[SLOT_W-1:0]];
         rd_port_ff  <= mem_port[idx_ff[SLOT_W-1:0]];
         rd_num_ff   <= mem_num[idx_ff[SLOT_W-1:0]];
         rd_allow_ff <= mem_allow[idx_ff[SLOT_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_SCAN)
      else $error("accepted item did not start a table scan");

   a_en_implies_used: assert property (@(posedge clock) disable iff (reset)
      (en_ff & ~used_ff) == '0)
      else $error("enable bit set on a free slot");

   a_add_advances: assert property (@(posedge clock) disable iff (reset)
      add_write |=> next_number_ff == $past(next_number_ff) + 32'd1)
      else $error("rule number did not advance after add");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> cmp_idx_ff <= LAST_SLOT)
      else $error("compare index beyond table");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> state_ff == S_DONE)
      else $error("result left while output register busy");

endmodule
